[sv/rar_pkg.sv]
`timescale 1ns / 1ps
package rar_pkg;

  localparam int NUM_W = 33;
  localparam int DEN_W = 32;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_ADD
  } front_state_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_GCD,
    B_DIV,
    B_DONE
  } back_state_e;

endpackage

[sv/rar_if.sv]
`timescale 1ns / 1ps
interface rar_in_if #(
  parameter int OPERAND_WIDTH = 16
);
  logic                             valid;
  logic                             ready;
  rar_pkg::cmd_e                    cmd;
  logic signed [OPERAND_WIDTH-1:0]  a_num;
  logic signed [OPERAND_WIDTH-1:0]  a_den;
  logic signed [OPERAND_WIDTH-1:0]  b_num;
  logic signed [OPERAND_WIDTH-1:0]  b_den;

  modport source (output valid, cmd, a_num, a_den, b_num, b_den, input ready);
  modport sink (input valid, cmd, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rar_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [rar_pkg::NUM_W-1:0] res_num;
  logic signed [rar_pkg::DEN_W-1:0] res_den;
  logic                             zero_den;

  modport source (output valid, res_num, res_den, zero_den, input ready);
  modport sink (input valid, res_num, res_den, zero_den, output ready);
endinterface

[sv/rar_front.sv]
`timescale 1ns / 1ps
module rar_front #(
  parameter int W  = 16,
  parameter int PW = 33
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  rar_pkg::cmd_e         cmd_i,
  input  logic signed [W-1:0]   a_num_i,
  input  logic signed [W-1:0]   a_den_i,
  input  logic signed [W-1:0]   b_num_i,
  input  logic signed [W-1:0]   b_den_i,
  output logic                  push_o,
  input  logic                  push_ready_i,
  output logic [2*PW:0]         push_data_o
);
  import rar_pkg::*;

  front_state_e state_q, state_d;
  cmd_e               cmd_q;
  logic signed [W-1:0]   an_q, ad_q, bn_q, bd_q;
  logic signed [W-1:0]   op_n0, op_d;
  logic signed [2*W-1:0] pn0_q, pn1_q, pd_q;
  logic signed [PW-1:0]  n0_ext, n1_ext, num, den;

  // the multiplier operand choice covers all four operations
  assign op_n0 = (cmd_q == CMD_MUL) ? bn_q : bd_q;
  assign op_d  = (cmd_q == CMD_DIV) ? bn_q : bd_q;

  assign n0_ext = PW'(pn0_q);
  assign n1_ext = PW'(pn1_q);
  assign den    = PW'(pd_q);

  always_comb begin
    case (cmd_q)
      CMD_ADD: num = n0_ext + n1_ext;
      CMD_SUB: num = n0_ext - n1_ext;
      default: num = n0_ext;
    endcase
  end

  assign push_data_o = {(den == '0), num, den};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_IDLE:  if (in_valid_i) state_d = F_MUL;
      F_MUL:   state_d = F_ADD;
      F_ADD:   if (push_ready_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    push_o     = 1'b0;
    unique case (state_q)
      F_IDLE:  in_ready_o = 1'b1;
      F_ADD:   push_o = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == F_IDLE && in_valid_i) begin
      cmd_q <= cmd_i;
      an_q  <= a_num_i;
      ad_q  <= a_den_i;
      bn_q  <= b_num_i;
      bd_q  <= b_den_i;
    end
    if (state_q == F_MUL) begin
      pn0_q <= an_q * op_n0;
      pn1_q <= bn_q * ad_q;
      pd_q  <= ad_q * op_d;
    end
  end

endmodule

[sv/rar_queue.sv]
`timescale 1ns / 1ps
module rar_queue #(
  parameter int DW = 67
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  output logic          push_ready_o,
  input  logic [DW-1:0] push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_i,
  output logic [DW-1:0] pop_data_o
);
  logic [DW-1:0] mem_q [2];
  logic          wr_q, rd_q;
  logic [1:0]    cnt_q;
  logic          do_push, do_pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = mem_q[rd_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= ~wr_q;
      if (do_pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_data_i;
  end

endmodule

[sv/rar_back.sv]
`timescale 1ns / 1ps
module rar_back #(
  parameter int PW = 33
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             pop_valid_i,
  output logic                             pop_o,
  input  logic [2*PW:0]                    pop_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [rar_pkg::NUM_W-1:0] res_num_o,
  output logic signed [rar_pkg::DEN_W-1:0] res_den_o,
  output logic                             zero_den_o
);
  import rar_pkg::*;

  localparam int KW = $clog2(PW + 1);

  back_state_e state_q, state_d;
  logic             zero_in;
  logic [PW-1:0]    num_in, den_in, num_mag, den_mag;
  logic [PW-1:0]    x_q, y_q, g_q, nq_q, dq_q;
  logic [PW:0]      nr_q, dr_q, nr_sh, dr_sh, nr_sub, dr_sub;
  logic [KW-1:0]    k_q, cnt_q;
  logic             num_neg_q, den_neg_q, zero_q, out_valid_q;
  logic             gcd_done, div_done, load_out;
  logic [PW-1:0]    num_s, den_s;
  logic signed [63:0] num_ext, den_ext;

  assign zero_in = pop_data_i[2*PW];
  assign num_in  = pop_data_i[2*PW-1:PW];
  assign den_in  = pop_data_i[PW-1:0];
  assign num_mag = num_in[PW-1] ? -num_in : num_in;
  assign den_mag = den_in[PW-1] ? -den_in : den_in;

  assign gcd_done = (x_q == '0) || (y_q == '0);
  assign div_done = (cnt_q == KW'(PW - 1));

  // one restoring step for each quotient
  assign nr_sh  = {nr_q[PW-1:0], nq_q[PW-1]};
  assign dr_sh  = {dr_q[PW-1:0], dq_q[PW-1]};
  assign nr_sub = nr_sh - {1'b0, g_q};
  assign dr_sub = dr_sh - {1'b0, g_q};

  assign num_s   = zero_q ? nq_q : (num_neg_q ? -nq_q : nq_q);
  assign den_s   = den_neg_q ? -dq_q : dq_q;
  assign num_ext = 64'($signed(num_s));
  assign den_ext = 64'($signed(den_s));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE: if (pop_valid_i) state_d = zero_in ? B_DONE : B_GCD;
      B_GCD:  if (gcd_done) state_d = B_DIV;
      B_DIV:  if (div_done) state_d = B_DONE;
      B_DONE: if (!out_valid_q || out_ready_i) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    pop_o    = 1'b0;
    load_out = 1'b0;
    unique case (state_q)
      B_IDLE:  pop_o = pop_valid_i;
      B_DONE:  load_out = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      B_IDLE: begin
        zero_q    <= zero_in;
        num_neg_q <= num_in[PW-1];
        den_neg_q <= den_in[PW-1];
        x_q       <= num_mag;
        y_q       <= den_mag;
        k_q       <= '0;
        nq_q      <= zero_in ? num_in : num_mag;
        dq_q      <= den_mag;
        nr_q      <= '0;
        dr_q      <= '0;
        cnt_q     <= '0;
      end
      B_GCD: begin
        if (x_q == '0) begin
          g_q <= y_q << k_q;
        end else if (y_q == '0) begin
          g_q <= x_q << k_q;
        end else if (!x_q[0] && !y_q[0]) begin
          x_q <= x_q >> 1;
          y_q <= y_q >> 1;
          k_q <= k_q + 1'b1;
        end else if (!x_q[0]) begin
          x_q <= x_q >> 1;
        end else if (!y_q[0]) begin
          y_q <= y_q >> 1;
        end else if (x_q >= y_q) begin
          x_q <= x_q - y_q;
        end else begin
          y_q <= y_q - x_q;
        end
      end
      B_DIV: begin
        nr_q  <= nr_sub[PW] ? nr_sh : nr_sub;
        dr_q  <= dr_sub[PW] ? dr_sh : dr_sub;
        nq_q  <= {nq_q[PW-2:0], ~nr_sub[PW]};
        dq_q  <= {dq_q[PW-2:0], ~dr_sub[PW]};
        cnt_q <= cnt_q + 1'b1;
      end
      default: ;
    endcase
    if (load_out) begin
      res_num_o  <= num_ext[NUM_W-1:0];
      res_den_o  <= zero_q ? '0 : den_ext[DEN_W-1:0];
      zero_den_o <= zero_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[sv/rational_arith_reduce.sv]
`timescale 1ns / 1ps
// Fraction add, subtract, multiply or divide with reduction to lowest terms. Each
// transaction is taken in, multiplied out (F_MUL), combined (F_ADD) and queued; the
// back end then runs a binary gcd (one shift or subtract per cycle) and two
// restoring dividers of P bits in parallel, where P = 2*OPERAND_WIDTH+1 capped at
// 64. Signs stay as computed, so the denominator may be negative; a zero
// denominator sets zero_den and returns the numerator unreduced. The front end
// accepts the next transaction while the back end and output are still busy, as
// long as the queue has room.
module rational_arith_reduce #(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rar_in_if.sink    in_i,
  rar_out_if.source out_o
);
  import rar_pkg::*;

  localparam int PW = (2 * OPERAND_WIDTH + 1 > 64) ? 64 : 2 * OPERAND_WIDTH + 1;

  logic          push, push_ready, pop, pop_valid;
  logic [2*PW:0] push_data, pop_data;

  rar_front #(.W(OPERAND_WIDTH), .PW(PW)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .cmd_i        (in_i.cmd),
    .a_num_i      (in_i.a_num),
    .a_den_i      (in_i.a_den),
    .b_num_i      (in_i.b_num),
    .b_den_i      (in_i.b_den),
    .push_o       (push),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  rar_queue #(.DW(2 * PW + 1)) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_data_o   (pop_data)
  );

  rar_back #(.PW(PW)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_o       (pop),
    .pop_data_i  (pop_data),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .res_num_o   (out_o.res_num),
    .res_den_o   (out_o.res_den),
    .zero_den_o  (out_o.zero_den)
  );

endmodule

[sv/rar_checker.sv]
`timescale 1ns / 1ps
module rar_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             out_valid_i,
  input logic                             out_ready_i,
  input logic signed [rar_pkg::NUM_W-1:0] res_num_i,
  input logic signed [rar_pkg::DEN_W-1:0] res_den_i,
  input logic                             zero_den_i
);
  import rar_pkg::*;

  // a stalled result holds its fields
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(res_num_i) &&
    $stable(res_den_i) && $stable(zero_den_i))
    else $error("result changed while stalled");

  a_zero_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && zero_den_i |-> res_den_i == '0)
    else $error("zero_den with nonzero denominator");

  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !zero_den_i |-> res_den_i != '0)
    else $error("zero denominator without zero_den");

  // a zero numerator reduces to zero over plus or minus one
  a_zero_num: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !zero_den_i && res_num_i == '0 |->
    res_den_i == DEN_W'(1) || res_den_i == '1)
    else $error("zero numerator not reduced");

endmodule

bind rational_arith_reduce rar_checker u_rar_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .res_num_i   (out_o.res_num),
  .res_den_i   (out_o.res_den),
  .zero_den_i  (out_o.zero_den)
);

[sim/tb_rational_arith_reduce.sv]
`timescale 1ns / 1ps
module tb_rational_arith_reduce;
  import rar_pkg::*;

  localparam int OW = 16;
  localparam int N_RANDOM = 700;
  localparam int LIMIT = 2000000;

  typedef struct packed {
    cmd_e            cmd;
    logic [OW-1:0]   a_num;
    logic [OW-1:0]   a_den;
    logic [OW-1:0]   b_num;
    logic [OW-1:0]   b_den;
  } frac_op_t;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    logic             zero_den;
  } frac_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  rar_in_if #(.OPERAND_WIDTH(OW)) in_if ();
  rar_out_if out_if ();

  rational_arith_reduce #(.OPERAND_WIDTH(OW)) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if.sink),
    .out_o (out_if.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  frac_op_t  pending_ops[$];
  frac_res_t reduced_q[$];
  bit        stim_done = 0;
  int        errors = 0;
  int        cycle = 0;
  int        hold_left = 0;
  bit        hold_done = 0;
  int        quiet_from, quiet_to;

  function automatic logic [63:0] mag64(logic [63:0] v);
    return v[63] ? -v : v;
  endfunction

  function automatic frac_res_t reduce_op(frac_op_t op);
    logic signed [63:0] an, ad, bn, bd, num, den;
    logic [63:0] x, y, t, qn, qd;
    frac_res_t r;
    an = 64'(signed'(op.a_num));
    ad = 64'(signed'(op.a_den));
    bn = 64'(signed'(op.b_num));
    bd = 64'(signed'(op.b_den));
    case (op.cmd)
      CMD_ADD: begin
        num = an * bd + bn * ad;
        den = ad * bd;
      end
      CMD_SUB: begin
        num = an * bd - bn * ad;
        den = ad * bd;
      end
      CMD_MUL: begin
        num = an * bn;
        den = ad * bd;
      end
      default: begin
        num = an * bd;
        den = ad * bn;
      end
    endcase
    if (den == 0) begin
      r.num = num[NUM_W-1:0];
      r.den = '0;
      r.zero_den = 1'b1;
      return r;
    end
    x = mag64(num);
    y = mag64(den);
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    qn = mag64(num) / x;
    qd = mag64(den) / x;
    if (num[63]) qn = -qn;
    if (den[63]) qd = -qd;
    r.num = qn[NUM_W-1:0];
    r.den = qd[DEN_W-1:0];
    r.zero_den = 1'b0;
    return r;
  endfunction

  function automatic logic [OW-1:0] rand_operand();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'(signed'($urandom_range(0, 8)) - 4);
      3, 4: return 16'(signed'($urandom_range(0, 64)) - 32);
      default: return OW'($urandom);
    endcase
  endfunction

  task automatic push_op(cmd_e c, int an, int ad, int bn, int bd);
    frac_op_t op;
    op.cmd = c;
    op.a_num = OW'(an);
    op.a_den = OW'(ad);
    op.b_num = OW'(bn);
    op.b_den = OW'(bd);
    pending_ops.push_back(op);
  endtask

  initial begin
    frac_op_t op;
    quiet_from = $urandom_range(3000, 8000);
    quiet_to = quiet_from + 6000;
    push_op(CMD_ADD, 1, 2, 1, 3);
    push_op(CMD_SUB, 1, 2, 1, 2);
    push_op(CMD_MUL, -3, 4, 2, -9);
    push_op(CMD_DIV, 5, 7, -10, 21);
    push_op(CMD_DIV, 5, 7, 0, 3);
    push_op(CMD_ADD, 1, 0, 2, 3);
    push_op(CMD_MUL, 0, 5, 7, -3);
    push_op(CMD_SUB, 0, 0, 0, 0);
    push_op(CMD_MUL, -32768, -32768, -32768, -32768);
    push_op(CMD_ADD, -32768, 1, -32768, 1);
    push_op(CMD_SUB, 32767, -32768, -32768, 32767);
    push_op(CMD_DIV, -32768, 32767, -32768, 1);
    push_op(CMD_ADD, 32767, 32767, 32767, 32767);
    push_op(CMD_MUL, -1, -1, -1, -1);
    push_op(CMD_DIV, 0, -5, 3, 4);
    push_op(CMD_SUB, 6, 4, -6, 4);
    for (int i = 0; i < N_RANDOM; i++) begin
      op.cmd = cmd_e'($urandom_range(0, 3));
      op.a_num = rand_operand();
      op.a_den = rand_operand();
      op.b_num = rand_operand();
      op.b_den = rand_operand();
      pending_ops.push_back(op);
    end
  end

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    frac_op_t op;
    bit quiet;
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.cmd <= CMD_ADD;
      in_if.a_num <= '0;
      in_if.a_den <= '0;
      in_if.b_num <= '0;
      in_if.b_den <= '0;
    end else begin
      quiet = cycle >= quiet_from && cycle < quiet_to;
      if (in_if.valid && in_if.ready) begin
        reduced_q.push_back(reduce_op({in_if.cmd, in_if.a_num, in_if.a_den,
                                       in_if.b_num, in_if.b_den}));
      end
      if (!in_if.valid || in_if.ready) begin
        if (pending_ops.size() > 0 && (quiet || $urandom_range(0, 99) >= 12)) begin
          op = pending_ops.pop_front();
          in_if.valid <= 1'b1;
          in_if.cmd <= op.cmd;
          in_if.a_num <= op.a_num;
          in_if.a_den <= op.a_den;
          in_if.b_num <= op.b_num;
          in_if.b_den <= op.b_den;
        end else begin
          in_if.valid <= 1'b0;
          if (pending_ops.size() == 0) stim_done <= 1'b1;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    frac_res_t exp_r;
    bit quiet;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      quiet = cycle >= quiet_from && cycle < quiet_to;
      if (out_if.valid && out_if.ready) begin
        if (reduced_q.size() == 0) begin
          $error("unexpected transaction: res_num %0d", out_if.res_num);
          errors++;
        end else begin
          exp_r = reduced_q.pop_front();
          if (out_if.res_num !== exp_r.num) begin
            $error("res_num expected %0d actual %0d",
                   $signed(exp_r.num), out_if.res_num);
            errors++;
          end
          if (out_if.res_den !== exp_r.den) begin
            $error("res_den expected %0d actual %0d",
                   $signed(exp_r.den), out_if.res_den);
            errors++;
          end
          if (out_if.zero_den !== exp_r.zero_den) begin
            $error("zero_den expected %0b actual %0b", exp_r.zero_den, out_if.zero_den);
            errors++;
          end
        end
      end
      if (!hold_done && cycle == 1500) begin
        hold_left = 3000;
        hold_done = 1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= quiet || $urandom_range(0, 99) >= 12;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle <= cycle + 1;
    if (cycle >= LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (stim_done && !in_if.valid && reduced_q.size() == 0);
    repeat (300) @(posedge clk_i);
    if (errors == 0 && reduced_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
